// File: hw/rtl/rsmm_pkg.sv
// ----------------------------------------------------------------------------
// rsmm_pkg: shared types and constants of the row stream matrix multiplier
// Beat structs of both channels, the beat that runs down the cell chain,
// and the register indexes of the configuration port.
// ----------------------------------------------------------------------------
package rsmm_pkg;

   localparam int ACC_W = 48;
   localparam int TAG_W = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_OUT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSE_W = 2'd3;

   localparam logic signed [ACC_W-1:0] SAT_HI = 48'sh0000_7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] SAT_LO = 48'shFFFF_8000_0000;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic [5:0]         column;
      logic               last_of_row;
      logic               last_of_matrix;
   } rsp_type;

   // One product on its way down the chain, tagged with its output column.
   typedef struct packed {
      logic                    valid;
      logic [TAG_W-1:0]        tag;
      logic signed [ACC_W-1:0] prod;
   } beat_type;

endpackage

// File: hw/rtl/row_stream_matrix_multiplier.sv
// ----------------------------------------------------------------------------
// row_stream_matrix_multiplier: Y = X * W (or X * W transposed), row by row
// Weight beats fill a store; X beats fill a row buffer. The last element of
// a row starts a sweep of the weight store through a chain of MAC cells,
// then the N column sums drain out, saturated to signed Q16.16.
// ----------------------------------------------------------------------------
// After the last X element of a row the sweep, the chain drain and the output
// phase follow in turn; the N results leave at one per cycle while the
// receiver does not stall. Weight beats and all but the last X beat of a row
// are taken every cycle; a row's last beat holds off the input through the
// sweep of the single-read-port weight store, the chain drain and the output.
// Synchronous reset clears counters, phase and valid flags and presets the
// registers; stores come up undefined and hold whatever is written to them.
module row_stream_matrix_multiplier #(
   parameter int MAX_K      = 64,
   parameter int MAX_N      = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rsmm_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rsmm_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [rsmm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rsmm_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rsmm_pkg::*;

   // Elements use at most the 16 bits of the field.
   localparam int EB    = (DATA_WIDTH > 16) ? 16 : DATA_WIDTH;
   localparam int DEPTH = MAX_K * MAX_N;
   localparam int KW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int NW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(MAX_N + 3);

   typedef enum logic [1:0] {IDLE, SWEEP, DRAIN, OUTPUT} phase_type;

   // Configuration registers.
   logic [6:0]  num_cols_ff, num_out_ff;
   logic [15:0] num_rows_ff;
   logic        transpose_ff;

   // Stream counters.
   logic [11:0] weight_count_ff;
   logic [KW-1:0] element_count_ff;
   logic [15:0] row_count_ff;

   // Stores.
   logic [EB-1:0] weight_store [DEPTH];
   logic [EB-1:0] x_row_buffer [MAX_K];

   // Sweep and drain control.
   phase_type   phase_ff;
   logic [AW-1:0] addr_ff;
   logic [KW-1:0] kc_ff;
   logic [NW-1:0] jc_ff;
   logic [6:0]  k_row_ff, n_row_ff;
   logic [12:0] total_row_ff;
   logic        tr_row_ff;
   logic        last_mat_ff;
   logic [CW-1:0] drain_ff;
   logic [6:0]  out_left_ff;
   logic [5:0]  out_col_ff;

   // Read stage and product stage.
   logic          s1_valid_ff;
   logic [5:0]    s1_tag_ff;
   logic [EB-1:0] w_rd_ff, x_rd_ff;
   beat_type      beat0_ff;

   // Output register.
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   // Clamped dimensions, as the model sees them.
   logic [6:0]  k_dim, n_dim;
   logic [16:0] rows_dim;
   logic [12:0] total_dim;
   logic        accept, acc_weight, acc_x, row_done, last_matrix;

   always_comb begin
      k_dim = num_cols_ff;
      if (num_cols_ff == 7'd0) k_dim = 7'd1;
      else if (num_cols_ff > 7'(MAX_K)) k_dim = 7'(MAX_K);
      n_dim = num_out_ff;
      if (num_out_ff == 7'd0) n_dim = 7'd1;
      else if (num_out_ff > 7'(MAX_N)) n_dim = 7'(MAX_N);
      rows_dim  = (num_rows_ff == 16'd0) ? 17'd1 : {1'b0, num_rows_ff};
      total_dim = 13'(k_dim) * 13'(n_dim);
   end

   assign req_stall   = (phase_ff != IDLE);
   assign accept      = req_valid && !req_stall;
   assign acc_weight  = accept && !req_data.kind;
   assign acc_x       = accept && req_data.kind;
   assign row_done    = acc_x && (8'(element_count_ff) + 8'd1 >= 8'(k_dim));
   assign last_matrix = (17'(row_count_ff) + 17'd1 >= rows_dim);

   always_ff @(posedge clock) begin
      if (reset) begin
         num_cols_ff  <= 7'd1;
         num_out_ff   <= 7'd1;
         num_rows_ff  <= 16'd1;
         transpose_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_NUM_COLS:    num_cols_ff  <= csr_wdata[6:0];
            CSR_NUM_OUT:     num_out_ff   <= csr_wdata[6:0];
            CSR_NUM_ROWS:    num_rows_ff  <= csr_wdata;
            CSR_TRANSPOSE_W: transpose_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Weight counter wraps after K*N beats; a stale count past the end
   // restarts at zero before the write.
   logic [12:0] wc_eff;
   assign wc_eff = (13'(weight_count_ff) >= total_dim) ? 13'd0 : 13'(weight_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_count_ff  <= '0;
         element_count_ff <= '0;
         row_count_ff     <= '0;
      end else begin
         if (acc_weight) begin
            weight_count_ff <= (wc_eff + 13'd1 >= total_dim) ? 12'd0 : 12'(wc_eff + 13'd1);
         end
         if (acc_x) begin
            element_count_ff <= row_done ? '0 : element_count_ff + KW'(1);
         end
         if (row_done) begin
            row_count_ff <= last_matrix ? 16'd0 : row_count_ff + 16'd1;
         end
      end
   end

   // Weight store: one write port from the input, one read port for the sweep.
   always_ff @(posedge clock) begin
      if (acc_weight) begin
         weight_store[AW'(wc_eff)] <= req_data.value[EB-1:0];
      end
      w_rd_ff <= weight_store[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (acc_x) begin
         x_row_buffer[element_count_ff] <= req_data.value[EB-1:0];
      end
      x_rd_ff <= x_row_buffer[kc_ff];
   end

   // Sweep walks the store in its own order; the inner counter is j for
   // the plain layout and k for the transposed one.
   logic sweep_last, inner_wrap;
   assign sweep_last = (13'(addr_ff) + 13'd1 == total_row_ff);
   assign inner_wrap = tr_row_ff ? (7'(kc_ff) + 7'd1 == k_row_ff)
                                 : (7'(jc_ff) + 7'd1 == n_row_ff);

   logic pop;
   assign pop = (phase_ff == OUTPUT) && (out_left_ff != 7'd0)
             && (!rsp_valid_ff || !rsp_stall);

   logic signed [ACC_W-1:0] acc [MAX_N+1];
   beat_type                beat [MAX_N+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= IDLE;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         out_left_ff  <= '0;
      end else begin
         s1_valid_ff <= (phase_ff == SWEEP);
         case (phase_ff)
            IDLE: begin
               if (row_done) begin
                  phase_ff     <= SWEEP;
                  addr_ff      <= '0;
                  kc_ff        <= '0;
                  jc_ff        <= '0;
                  k_row_ff     <= k_dim;
                  n_row_ff     <= n_dim;
                  total_row_ff <= total_dim;
                  tr_row_ff    <= transpose_ff;
                  last_mat_ff  <= last_matrix;
               end
            end
            SWEEP: begin
               addr_ff <= addr_ff + AW'(1);
               if (tr_row_ff) begin
                  kc_ff <= inner_wrap ? '0 : kc_ff + KW'(1);
                  if (inner_wrap) jc_ff <= jc_ff + NW'(1);
               end else begin
                  jc_ff <= inner_wrap ? '0 : jc_ff + NW'(1);
                  if (inner_wrap) kc_ff <= kc_ff + KW'(1);
               end
               if (sweep_last) begin
                  phase_ff <= DRAIN;
                  drain_ff <= '0;
               end
            end
            DRAIN: begin
               drain_ff <= drain_ff + CW'(1);
               if (drain_ff == CW'(MAX_N)) begin
                  phase_ff    <= OUTPUT;
                  out_left_ff <= n_row_ff;
                  out_col_ff  <= '0;
               end
            end
            OUTPUT: begin
               if (pop) begin
                  out_left_ff <= out_left_ff - 7'd1;
                  out_col_ff  <= out_col_ff + 6'd1;
               end else if (out_left_ff == 7'd0) begin
                  phase_ff <= IDLE;
               end
            end
            default: phase_ff <= IDLE;
         endcase
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff <= 6'(jc_ff);
   end

   // Product stage feeds the head of the chain.
   logic signed [EB-1:0]   xs, ws;
   logic signed [2*EB-1:0] prod;
   assign xs   = x_rd_ff;
   assign ws   = w_rd_ff;
   assign prod = xs * ws;

   always_ff @(posedge clock) begin
      beat0_ff.tag  <= s1_tag_ff;
      beat0_ff.prod <= ACC_W'(prod);
      if (reset) begin
         beat0_ff.valid <= 1'b0;
      end else begin
         beat0_ff.valid <= s1_valid_ff;
      end
   end

   assign beat[0]    = beat0_ff;
   assign acc[MAX_N] = '0;

   for (genvar i = 0; i < MAX_N; i++) begin : g_cell
      rsmm_cell #(.INDEX(i)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (row_done),
         .shift    (pop),
         .beat_in  (beat[i]),
         .acc_in   (acc[i+1]),
         .beat_out (beat[i+1]),
         .acc_out  (acc[i])
      );
   end

   // The head cell's sum saturates into the output register.
   logic signed [31:0] sat;
   always_comb begin
      if (acc[0] > SAT_HI) sat = 32'sh7FFF_FFFF;
      else if (acc[0] < SAT_LO) sat = 32'sh8000_0000;
      else sat = acc[0][31:0];
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff.result         <= sat;
         rsp_ff.column         <= out_col_ff;
         rsp_ff.last_of_row    <= (out_left_ff == 7'd1);
         rsp_ff.last_of_matrix <= (out_left_ff == 7'd1) && last_mat_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_from_output: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(phase_ff == OUTPUT))
      else $error("result appeared outside the output phase");
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last_of_row |-> 7'(rsp_ff.column) + 7'd1 == n_row_ff)
      else $error("last_of_row on wrong column");
   a_mat_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last_of_matrix |-> rsp_ff.last_of_row)
      else $error("last_of_matrix without last_of_row");
   a_chain_idle: assert property (@(posedge clock) disable iff (reset)
      beat[MAX_N].valid |-> phase_ff != IDLE)
      else $error("product left the chain while idle");

endmodule

// File: hw/rtl/rsmm_cell.sv
// ----------------------------------------------------------------------------
// rsmm_cell: one accumulator cell of the chain
// Adds the passing product when its tag names this cell, forwards the beat,
// and shifts its sum toward the head of the chain while results drain.
// ----------------------------------------------------------------------------
module rsmm_cell #(
   parameter int INDEX = 0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  logic                             shift,
   input  rsmm_pkg::beat_type               beat_in,
   input  logic signed [rsmm_pkg::ACC_W-1:0] acc_in,
   output rsmm_pkg::beat_type               beat_out,
   output logic signed [rsmm_pkg::ACC_W-1:0] acc_out
);
   import rsmm_pkg::*;

   beat_type                beat_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in_next;

   always_comb begin
      acc_in_next = acc_ff;
      if (clear) begin
         acc_in_next = '0;
      end else if (shift) begin
         acc_in_next = acc_in;
      end else if (beat_in.valid && beat_in.tag == TAG_W'(INDEX)) begin
         acc_in_next = acc_ff + beat_in.prod;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in_next;
      beat_ff.tag <= beat_in.tag;
      beat_ff.prod <= beat_in.prod;
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else begin
         beat_ff.valid <= beat_in.valid;
      end
   end

   assign beat_out = beat_ff;
   assign acc_out  = acc_ff;

endmodule

// File: tb/tb_row_stream_matrix_multiplier.sv
// ----------------------------------------------------------------------------
// tb_row_stream_matrix_multiplier: self-checking bench of the matrix multiplier
// Loads full weight sets under a series of register settings, streams X rows
// and checks every result beat against a predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
module tb_row_stream_matrix_multiplier;
   import rsmm_pkg::*;

   // The scoreboard keeps its own copy of the weight store, the row buffer,
   // the counters and the registers, and predicts the column sums of a row
   // when its last element is accepted.
   class product_scoreboard;
      logic [15:0] weights[4096];
      logic [15:0] xrow[64];
      int unsigned wcount, ecount, rcount;
      int unsigned cols, outs, rows, trans;
      rsp_type     expected_results[$];
      int          errors;

      function new();
         foreach (weights[i]) weights[i] = '0;
         foreach (xrow[i]) xrow[i] = '0;
         wcount = 0; ecount = 0; rcount = 0;
         cols = 1; outs = 1; rows = 1; trans = 0;
         errors = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
         case (idx)
            CSR_NUM_COLS:    cols = d[6:0];
            CSR_NUM_OUT:     outs = d[6:0];
            CSR_NUM_ROWS:    rows = d;
            CSR_TRANSPOSE_W: trans = d[0];
            default: ;
         endcase
      endfunction

      function int unsigned k_dim();
         return (cols < 1) ? 1 : (cols > 64) ? 64 : cols;
      endfunction

      function int unsigned n_dim();
         return (outs < 1) ? 1 : (outs > 64) ? 64 : outs;
      endfunction

      function void note_input(req_type b);
         int unsigned kd, nd, total, eff_rows, addr;
         bit          last_mat;
         longint      acc;
         rsp_type     r;
         kd = k_dim();
         nd = n_dim();
         eff_rows = (rows == 0) ? 1 : rows;
         if (b.kind == 1'b0) begin
            total = kd * nd;
            if (wcount >= total) wcount = 0;
            weights[wcount % 4096] = b.value;
            wcount = (wcount + 1 >= total) ? 0 : wcount + 1;
            return;
         end
         if (ecount < 64) xrow[ecount] = b.value;
         if (ecount + 1 < kd) begin
            ecount = (ecount + 1) & 6'h3f;
            return;
         end
         ecount = 0;
         last_mat = (rcount + 1 >= eff_rows);
         rcount = last_mat ? 0 : ((rcount + 1) & 16'hffff);
         for (int j = 0; j < nd; j++) begin
            acc = 0;
            for (int k = 0; k < kd; k++) begin
               addr = trans ? (j * kd + k) : (k * nd + j);
               acc += longint'($signed(weights[addr % 4096])) *
                      longint'($signed(xrow[k]));
            end
            if (acc > SAT_HI) acc = SAT_HI;
            if (acc < SAT_LO) acc = SAT_LO;
            r.result = acc[31:0];
            r.column = j[5:0];
            r.last_of_row = (j + 1 == nd);
            r.last_of_matrix = (j + 1 == nd) && last_mat;
            expected_results.push_back(r);
         end
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("mismatch: %s got %0d expected %0d", what, got, want);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result beat, result", longint'(got.result), 0);
            return;
         end
         want = expected_results.pop_front();
         if (got.result != want.result)
            report_mismatch("result", longint'(got.result), longint'(want.result));
         if (got.column != want.column)
            report_mismatch("column", longint'(got.column), longint'(want.column));
         if (got.last_of_row != want.last_of_row)
            report_mismatch("last_of_row", longint'(got.last_of_row),
                            longint'(want.last_of_row));
         if (got.last_of_matrix != want.last_of_matrix)
            report_mismatch("last_of_matrix", longint'(got.last_of_matrix),
                            longint'(want.last_of_matrix));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   product_scoreboard sb;
   bit                send_idle;    // Sender may insert gaps between beats.
   bit                recv_idle;    // Receiver may stall in random bursts.
   bit                hold_request; // Asks the receiver for one long hold-off.
   int                beats_sent;

   row_stream_matrix_multiplier dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // Offers one beat and waits until it is taken. The valid is held across
   // back-to-back beats; a gap, when one is drawn, lowers it after the accept.
   task automatic send_beat(input logic kind, input logic [15:0] value);
      req_type b;
      b.kind = kind;
      b.value = value;
      req_valid <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (req_stall);
      sb.note_input(b);
      beats_sent++;
      if (send_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   function automatic logic [15:0] pick_element();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return 16'($urandom());
      endcase
   endfunction

   // Waits until every predicted result has come out, then lets the pipeline
   // settle for a full row latency before the registers may change.
   task automatic wait_idle();
      int unsigned settle;
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.expected_results.size() != 0);
      settle = sb.k_dim() * sb.n_dim() + 64 + 10;
      repeat (settle) @(posedge clock);
   endtask

   // Writes all four registers on consecutive edges, lowering the enable once.
   task automatic configure(input int unsigned k, input int unsigned n,
                            input int unsigned r, input int unsigned t);
      logic [CSR_DATA_W-1:0] vals[4];
      logic [CSR_IDX_W-1:0]  idxs[4];
      vals = '{CSR_DATA_W'(k), CSR_DATA_W'(n), CSR_DATA_W'(r), CSR_DATA_W'(t)};
      idxs = '{CSR_NUM_COLS, CSR_NUM_OUT, CSR_NUM_ROWS, CSR_TRANSPOSE_W};
      for (int i = 0; i < 4; i++) begin
         csr_we <= 1'b1;
         csr_index <= idxs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_reg(idxs[i], vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic load_weights(input int unsigned count, input int mode);
      for (int i = 0; i < count; i++)
         case (mode)
            1: send_beat(1'b0, 16'h8000);
            2: send_beat(1'b0, 16'h7fff);
            default: send_beat(1'b0, pick_element());
         endcase
   endtask

   task automatic send_row(input int mode);
      for (int i = 0; i < sb.k_dim(); i++)
         case (mode)
            1: send_beat(1'b1, 16'h8000);
            default: send_beat(1'b1, pick_element());
         endcase
   endtask

   // One random phase: a full weight set so that every read entry is defined,
   // then mostly whole rows, with partial reloads and split rows as noise.
   // The phase closes on a row boundary.
   task automatic random_phase(input int unsigned nbeats);
      int unsigned start;
      start = beats_sent;
      load_weights(sb.k_dim() * sb.n_dim(), 0);
      while (beats_sent - start < nbeats) begin
         case ($urandom_range(0, 9))
            0: load_weights($urandom_range(1, sb.k_dim() * sb.n_dim()), 0);
            1: repeat ($urandom_range(1, sb.k_dim())) send_beat(1'b1, pick_element());
            default: send_row(0);
         endcase
      end
      while (sb.ecount != 0) send_beat(1'b1, pick_element());
   endtask

   // Result side: checks each accepted beat and redraws the stall.
   initial begin : receiver
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (recv_idle && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      sb = new();
      send_idle = 1'b1;
      recv_idle = 1'b1;
      hold_request = 1'b0;
      beats_sent = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: a single weight and single-element rows at the extremes.
      send_beat(1'b0, 16'h7fff);
      send_beat(1'b1, 16'h8000);
      send_beat(1'b1, 16'h7fff);
      send_beat(1'b0, 16'h8000);
      send_beat(1'b1, 16'h8000);
      send_beat(1'b1, 16'h0000);
      wait_idle();

      // Three products of the most negative operands pile up past the positive limit,
      // and a zero row count acts as one.
      configure(3, 1, 0, 0);
      load_weights(3, 1);
      send_row(1);
      wait_idle();
      // Largest positive weights against the most negative X saturate low.
      load_weights(3, 2);
      send_row(1);
      wait_idle();

      // Zero output columns act as one; output count written above its range
      // saturates to the widest output, here with a transposed store.
      configure(1, 0, 3, 1);
      load_weights(1, 0);
      send_row(0);
      send_row(0);
      wait_idle();
      configure(1, 127, 65535, 1);
      load_weights(64, 0);
      send_row(0);
      send_row(0);
      wait_idle();

      // Fill the block while the receiver holds off for a long stretch.
      configure(2, 3, 4, 0);
      load_weights(6, 0);
      hold_request = 1'b1;
      repeat (12) send_row(0);
      wait_idle();

      // Random small settings, zero dimensions included; the last phase runs
      // without idling.
      for (int p = 0; p < 3; p++) begin
         if (p == 2) begin
            send_idle = 1'b0;
            recv_idle = 1'b0;
         end
         configure($urandom_range(0, 3), $urandom_range(0, 3),
                   $urandom_range(0, 4), $urandom_range(0, 1));
         random_phase(10);
         wait_idle();
      end

      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : watchdog
      #20000000;
      $display("status: fail");
      $finish;
   end

endmodule
